FILE: rtl/core/ordered_list_insert_delete_macros.svh
// Assertion macros shared by the ordered list checker.
// No dependencies; include by bare file name.
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

// assert under reset disable
`define OLID_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert at every edge, reset included
`define OLID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/olid_pkg.sv
// Shared types and constants for the ordered list insert/delete block.
// No dependencies.
package olid_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 7;
  localparam int CNT_W     = 7;
  localparam int CAP_W     = 7;
  localparam int ST_W      = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos_m1;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/olid_cell.sv
// One storage cell of the list chain: holds one entry, shifts with neighbors.
// Depends on olid_pkg.
module olid_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  olid_pkg::cell_ctrl_t         ctrl,
  input  logic [olid_pkg::VAL_W-1:0]   ins_value,
  input  logic [olid_pkg::VAL_W-1:0]   left_q,
  input  logic [olid_pkg::VAL_W-1:0]   right_q,
  output logic [olid_pkg::VAL_W-1:0]   q,
  output logic [olid_pkg::VAL_W-1:0]   sel_q
);
  import olid_pkg::*;

  logic [VAL_W-1:0] q_r;
  logic [VAL_W-1:0] q_nxt;
  logic             at_pos;
  logic             above_pos;

  assign at_pos    = (int'(ctrl.pos_m1) == IDX);
  assign above_pos = (IDX > int'(ctrl.pos_m1));

  always_comb begin
    priority if (ctrl.ins && at_pos) begin
      q_nxt = ins_value;
    end else if (ctrl.ins && above_pos) begin
      q_nxt = left_q;
    end else if (ctrl.del && (at_pos || above_pos)) begin
      q_nxt = right_q;
    end else begin
      q_nxt = q_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q     = q_r;
  assign sel_q = at_pos ? q_r : '0;

endmodule

FILE: rtl/core/ordered_list_insert_delete.sv
// Top level of the ordered list insert/delete block: control and cell chain.
// Depends on olid_pkg and olid_cell.
//
// Usage:
//   Requests enter on in_valid/in_stall with in_op (insert or delete),
//   in_position (1-based) and in_value. Each request yields one result on
//   out_valid/out_stall: out_status, out_removed_value and out_count.
//   A request is taken at an edge with in_valid high and in_stall low; its
//   result is registered and appears in the cycle after. Every cell of
//   the chain shifts at once, so one request per cycle is sustained while
//   out_stall is low; the single output register sets that rate.
//   While out_stall holds a waiting result, in_stall is raised and the
//   result stays unchanged.
//   cfg_wr_en/cfg_wr_data write the capacity register; write only while
//   no result is pending.
//   Reset (rst_n low, synchronous) empties the list, drops any pending
//   result and sets capacity to 64. Entries are not cleared.
module ordered_list_insert_delete #(
  parameter int DEPTH = olid_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [olid_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [olid_pkg::POS_W-1:0]  in_position,
  input  logic [olid_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [olid_pkg::ST_W-1:0]   out_status,
  output logic [olid_pkg::VAL_W-1:0]  out_removed_value,
  output logic [olid_pkg::CNT_W-1:0]  out_count
);
  import olid_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CAP =
    (DEPTH > 127) ? CNT_W'(127) : CNT_W'(DEPTH);

  logic [CAP_W-1:0] capacity_r;
  logic [CAP_W-1:0] capacity_nxt;
  logic [CNT_W-1:0] length_r;
  logic [CNT_W-1:0] length_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  status_t          status_nxt;
  logic [VAL_W-1:0] removed_r;
  logic [VAL_W-1:0] removed_nxt;
  logic [CNT_W-1:0] count_r;

  logic             accept;
  logic [CNT_W-1:0] eff_cap;
  logic             ins_pos_ok;
  logic             del_pos_ok;
  logic             full;
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] removed_sel;

  logic [VAL_W-1:0] cell_q   [DEPTH];
  logic [VAL_W-1:0] cell_sel [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign eff_cap    = (capacity_r < DEPTH_CAP) ? capacity_r : DEPTH_CAP;
  assign ins_pos_ok = (in_position != '0) &&
                      ({1'b0, in_position} <= ({1'b0, length_r} + 8'd1));
  assign del_pos_ok = (in_position != '0) && (in_position <= length_r);
  assign full       = (length_r >= eff_cap);

  always_comb begin
    status_nxt  = ST_OK;
    ctrl.ins    = 1'b0;
    ctrl.del    = 1'b0;
    ctrl.pos_m1 = in_position - POS_W'(1);
    length_nxt  = length_r;
    removed_nxt = '0;
    if (in_op == OP_INSERT) begin
      priority if (!ins_pos_ok) begin
        status_nxt = ST_BAD_POS;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        ctrl.ins   = accept;
        length_nxt = length_r + CNT_W'(1);
      end
    end else begin
      if (!del_pos_ok) begin
        status_nxt = ST_BAD_POS;
      end else begin
        ctrl.del    = accept;
        length_nxt  = length_r - CNT_W'(1);
        removed_nxt = removed_sel;
      end
    end
  end

  always_comb begin
    removed_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed_sel = removed_sel | cell_sel[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] left_q;
    logic [VAL_W-1:0] right_q;
    if (g == 0) begin : g_first
      assign left_q = in_value;
    end else begin : g_mid
      assign left_q = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_q = cell_q[g];
    end else begin : g_inner
      assign right_q = cell_q[g+1];
    end
    olid_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ins_value (in_value),
      .left_q    (left_q),
      .right_q   (right_q),
      .q         (cell_q[g]),
      .sel_q     (cell_sel[g])
    );
  end

  assign capacity_nxt  = cfg_wr_en ? cfg_wr_data : capacity_r;
  assign out_valid_nxt = accept ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      capacity_r  <= capacity_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        length_r <= length_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      count_r   <= length_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_count         = count_r;

endmodule

FILE: rtl/core/olid_checker.sv
// Port-level checker for the ordered list block, bound to the top level.
// Depends on olid_pkg and ordered_list_insert_delete_macros.svh.
`include "ordered_list_insert_delete_macros.svh"

module olid_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_wr_en,
  input logic [olid_pkg::CAP_W-1:0]  cfg_wr_data,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_op,
  input logic [olid_pkg::POS_W-1:0]  in_position,
  input logic [olid_pkg::VAL_W-1:0]  in_value,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [olid_pkg::ST_W-1:0]   out_status,
  input logic [olid_pkg::VAL_W-1:0]  out_removed_value,
  input logic [olid_pkg::CNT_W-1:0]  out_count
);
  import olid_pkg::*;

  `OLID_ASSERT_RST(a_status_legal, clk, rst_n,
    out_valid |-> (out_status == ST_OK || out_status == ST_BAD_POS || out_status == ST_FULL),
    "illegal status code")

  `OLID_ASSERT_RST(a_reject_no_value, clk, rst_n,
    (out_valid && out_status != ST_OK) |-> (out_removed_value == '0),
    "rejected request carries a removed value")

  `OLID_ASSERT_ALWAYS(a_stall_needs_result, clk,
    in_stall |-> out_valid,
    "input stalled with no pending result")

  `OLID_ASSERT_RST(a_request_gives_result, clk, rst_n,
    (in_valid && !in_stall) |=> out_valid,
    "accepted request produced no result")

endmodule

bind ordered_list_insert_delete olid_checker u_olid_checker (.*);
